// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the linked list engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/blle_pkg.sv -----
// Types and codes shared by the linked list engine files.
`default_nettype none

package blle_pkg;

  typedef logic [1:0]         mode_t;
  typedef logic [1:0]         status_t;
  typedef logic signed [31:0] data_t;
  typedef logic [4:0]         pos_t;
  typedef logic [5:0]         count_t;

  localparam mode_t MODE_INS_FRONT = 2'd0;
  localparam mode_t MODE_INS_BACK  = 2'd1;
  localparam mode_t MODE_SEARCH    = 2'd2;
  localparam mode_t MODE_DELETE    = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_EMPTY     = 2'd2;
  localparam status_t ST_NOT_FOUND = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/blle_if.sv -----
// Request and response channel interfaces of the linked list engine.
`default_nettype none

interface blle_req_if;
  logic                  valid;
  logic                  ready;
  blle_pkg::mode_t       mode;
  blle_pkg::data_t       value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

interface blle_rsp_if;
  logic                  valid;
  logic                  ready;
  blle_pkg::status_t     status;
  logic                  found;
  blle_pkg::pos_t        position;
  blle_pkg::count_t      count;

  modport source (output valid, output status, output found, output position, output count,
                  input ready);
  modport sink (input valid, input status, input found, input position, input count,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/blle_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module blle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/bounded_linked_list_engine_unit.sv -----
// Top level of the bounded singly linked list engine.
`default_nettype none

// The engine keeps up to CAPACITY signed 32-bit values in a singly linked list held in two
// RAMs, one for values and one for next links; freed slots are chained through the link RAM
// and slots never used are handed out by a fill counter, so no clearing pass follows reset.
// It handles one request at a time. An insert goes from acceptance through dispatch, a pop of
// the free list when a freed slot is reused, the write of the slot and, when appending to a
// list that is not empty, the link from the old tail, to its response word. A search or delete
// visits one list entry per cycle, as set by the registered read of the two RAMs, up to the
// entry count, and a delete that matches then unlinks the entry. The next request is accepted
// while the previous response word still waits to be taken.
module bounded_linked_list_engine_unit #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  blle_req_if.sink    req_i,
  blle_rsp_if.source  rsp_o
);

  localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DISP = 3'd1;
  localparam logic [2:0] ST_POP  = 3'd2;
  localparam logic [2:0] ST_INS  = 3'd3;
  localparam logic [2:0] ST_LINK = 3'd4;
  localparam logic [2:0] ST_WALK = 3'd5;
  localparam logic [2:0] ST_DEL  = 3'd6;
  localparam logic [2:0] ST_RESP = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [SW-1:0]     head_q, head_d;
  logic [SW-1:0]     tail_q, tail_d;
  logic [SW-1:0]     free_head_q, free_head_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     fresh_q, fresh_d;
  logic              out_valid_q, out_valid_d;

  blle_pkg::mode_t   mode_q, mode_d;
  logic [31:0]       val_q, val_d;
  logic [SW-1:0]     cur_q, cur_d;
  logic [SW-1:0]     prev_q, prev_d;
  logic [SW-1:0]     nxt_q, nxt_d;
  logic [SW-1:0]     slot_q, slot_d;
  logic [CW-1:0]     idx_q, idx_d;
  blle_pkg::status_t res_status_q, res_status_d;
  logic              res_found_q, res_found_d;
  blle_pkg::pos_t    res_pos_q, res_pos_d;
  blle_pkg::status_t out_status_q, out_status_d;
  logic              out_found_q, out_found_d;
  blle_pkg::pos_t    out_pos_q, out_pos_d;
  blle_pkg::count_t  out_count_q, out_count_d;

  logic              val_we;
  logic [SW-1:0]     val_waddr;
  logic [31:0]       val_rdata;
  logic              lnk_we;
  logic [SW-1:0]     lnk_waddr;
  logic [SW-1:0]     lnk_wdata;
  logic [SW-1:0]     lnk_rdata;
  logic [SW-1:0]     rd_addr;

  logic              is_insert;
  logic              hit;
  logic [CW-1:0]     idx_inc;

  assign is_insert = (mode_q == blle_pkg::MODE_INS_FRONT) || (mode_q == blle_pkg::MODE_INS_BACK);
  assign hit       = (val_rdata == val_q);
  assign idx_inc   = idx_q + CW'(1);
  assign val_waddr = slot_q;

  blle_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_q),
    .raddr_i (rd_addr),
    .rdata_o (val_rdata)
  );

  blle_ram #(
    .WIDTH (SW),
    .DEPTH (CAPACITY)
  ) u_lnk_ram (
    .clk_i   (clk_i),
    .we_i    (lnk_we),
    .waddr_i (lnk_waddr),
    .wdata_i (lnk_wdata),
    .raddr_i (rd_addr),
    .rdata_o (lnk_rdata)
  );

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    free_head_d  = free_head_q;
    count_d      = count_q;
    fresh_d      = fresh_q;
    out_valid_d  = out_valid_q;
    mode_d       = mode_q;
    val_d        = val_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    nxt_d        = nxt_q;
    slot_d       = slot_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_pos_d    = res_pos_q;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_pos_d    = out_pos_q;
    out_count_d  = out_count_q;
    val_we       = 1'b0;
    lnk_we       = 1'b0;
    lnk_waddr    = cur_q;
    lnk_wdata    = '0;
    rd_addr      = cur_q;

    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          mode_d  = req_i.mode;
          val_d   = req_i.value;
          cur_d   = head_q;
          prev_d  = head_q;
          idx_d   = '0;
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        res_status_d = blle_pkg::ST_OK;
        res_found_d  = 1'b0;
        res_pos_d    = '0;
        if (is_insert) begin
          if (count_q == CW'(CAPACITY)) begin
            res_status_d = blle_pkg::ST_FULL;
            state_d      = ST_RESP;
          end else if (fresh_q != count_q) begin
            rd_addr = free_head_q;
            state_d = ST_POP;
          end else begin
            slot_d  = fresh_q[SW-1:0];
            fresh_d = fresh_q + CW'(1);
            state_d = ST_INS;
          end
        end else if (count_q == '0) begin
          res_status_d = blle_pkg::ST_EMPTY;
          state_d      = ST_RESP;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_POP: begin
        slot_d      = free_head_q;
        free_head_d = lnk_rdata;
        state_d     = ST_INS;
      end
      ST_INS: begin
        val_we    = 1'b1;
        lnk_we    = 1'b1;
        lnk_waddr = slot_q;
        lnk_wdata = ((count_q != '0) && (mode_q == blle_pkg::MODE_INS_FRONT)) ? head_q : '0;
        count_d   = count_q + CW'(1);
        if (count_q == '0) begin
          head_d  = slot_q;
          tail_d  = slot_q;
          state_d = ST_RESP;
        end else if (mode_q == blle_pkg::MODE_INS_FRONT) begin
          head_d  = slot_q;
          state_d = ST_RESP;
        end else begin
          state_d = ST_LINK;
        end
      end
      ST_LINK: begin
        lnk_we    = 1'b1;
        lnk_waddr = tail_q;
        lnk_wdata = slot_q;
        tail_d    = slot_q;
        state_d   = ST_RESP;
      end
      ST_WALK: begin
        if (hit) begin
          res_found_d = 1'b1;
          res_pos_d   = blle_pkg::pos_t'(idx_q);
          if (mode_q == blle_pkg::MODE_DELETE) begin
            lnk_we      = 1'b1;
            lnk_waddr   = cur_q;
            lnk_wdata   = free_head_q;
            free_head_d = cur_q;
            nxt_d       = lnk_rdata;
            state_d     = ST_DEL;
          end else begin
            state_d = ST_RESP;
          end
        end else if (idx_inc == count_q) begin
          res_status_d = blle_pkg::ST_NOT_FOUND;
          state_d      = ST_RESP;
        end else begin
          prev_d  = cur_q;
          cur_d   = lnk_rdata;
          idx_d   = idx_inc;
          rd_addr = lnk_rdata;
        end
      end
      ST_DEL: begin
        if (idx_q == '0) begin
          head_d = nxt_q;
        end else begin
          lnk_we    = 1'b1;
          lnk_waddr = prev_q;
          lnk_wdata = nxt_q;
        end
        if (cur_q == tail_q) begin
          tail_d = prev_q;
        end
        count_d = count_q - CW'(1);
        if (count_q == CW'(1)) begin
          head_d = '0;
          tail_d = '0;
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_found_d  = res_found_q;
          out_pos_d    = res_pos_q;
          out_count_d  = blle_pkg::count_t'(count_q);
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      free_head_q <= '0;
      count_q     <= '0;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      free_head_q <= free_head_d;
      count_q     <= count_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    val_q        <= val_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    nxt_q        <= nxt_d;
    slot_q       <= slot_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_pos_q    <= res_pos_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_pos_q    <= out_pos_d;
    out_count_q  <= out_count_d;
  end

  assign req_i.ready    = (state_q == ST_IDLE);
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.status   = out_status_q;
  assign rsp_o.found    = out_found_q;
  assign rsp_o.position = out_pos_q;
  assign rsp_o.count    = out_count_q;

endmodule

`default_nettype wire

// ----- rtl/blle_chk.sv -----
// Port-level checker of the linked list engine and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module blle_chk (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              req_valid_i,
  input wire logic              req_ready_i,
  input wire logic              rsp_valid_i,
  input wire logic              rsp_ready_i,
  input wire blle_pkg::status_t rsp_status_i,
  input wire logic              rsp_found_i,
  input wire blle_pkg::pos_t    rsp_position_i,
  input wire blle_pkg::count_t  rsp_count_i
);

  `ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_count_i))
  `ASSERT_IMPLY(a_found_ok, clk_i, rst_ni, rsp_valid_i && rsp_found_i, rsp_status_i == blle_pkg::ST_OK)
  `ASSERT_IMPLY(a_fail_clean, clk_i, rst_ni, rsp_valid_i && (rsp_status_i != blle_pkg::ST_OK), !rsp_found_i && (rsp_position_i == '0))
  `ASSERT_IMPLY(a_empty_count, clk_i, rst_ni, rsp_valid_i && (rsp_status_i == blle_pkg::ST_EMPTY), rsp_count_i == '0)
  `ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)

endmodule

bind bounded_linked_list_engine_unit blle_chk u_blle_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_status_i   (rsp_o.status),
  .rsp_found_i    (rsp_o.found),
  .rsp_position_i (rsp_o.position),
  .rsp_count_i    (rsp_o.count)
);

`default_nettype wire

// ----- bench/tb_bounded_linked_list_engine_unit.sv -----
// Testbench for the bounded linked list engine: random requests checked against a list mirror.
module tb_bounded_linked_list_engine_unit;

  localparam int unsigned CAPACITY = 32;

  typedef struct packed {
    blle_pkg::status_t status;
    logic              found;
    blle_pkg::pos_t    position;
    blle_pkg::count_t  count;
  } reply_t;

  typedef enum int {ALWAYS_READY, COIN_FLIP, EVERY_THIRD, MOSTLY_STALLED} stall_style_t;
  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} segment_t;

  class list_mirror;
    blle_pkg::data_t mirror_values[$];
    reply_t          pending_replies[$];
    int unsigned     capacity;
    int unsigned     errors, requests, replies, hits, fulls, empties, misses, peak;

    function new(int unsigned cap);
      capacity = cap;
    endfunction

    function void note_request(blle_pkg::mode_t m, blle_pkg::data_t v);
      reply_t w;
      int     hit;
      w = '0;
      w.status = blle_pkg::ST_OK;
      hit = -1;
      requests++;
      if (m == blle_pkg::MODE_INS_FRONT || m == blle_pkg::MODE_INS_BACK) begin
        if (mirror_values.size() >= capacity) begin
          w.status = blle_pkg::ST_FULL;
          fulls++;
        end else if (m == blle_pkg::MODE_INS_FRONT) begin
          mirror_values.push_front(v);
        end else begin
          mirror_values.push_back(v);
        end
      end else if (mirror_values.size() == 0) begin
        w.status = blle_pkg::ST_EMPTY;
        empties++;
      end else begin
        foreach (mirror_values[i])
          if (hit < 0 && mirror_values[i] == v) hit = i;
        if (hit < 0) begin
          w.status = blle_pkg::ST_NOT_FOUND;
          misses++;
        end else begin
          w.found = 1'b1;
          w.position = blle_pkg::pos_t'(hit);
          hits++;
          if (m == blle_pkg::MODE_DELETE) mirror_values.delete(hit);
        end
      end
      w.count = blle_pkg::count_t'(mirror_values.size());
      if (mirror_values.size() > peak) peak = mirror_values.size();
      pending_replies.push_back(w);
    endfunction

    task report(string what);
      if (errors < 30) $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_reply(reply_t got);
      reply_t want;
      replies++;
      if (pending_replies.size() == 0) begin
        report("response word arrived with nothing expected");
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status)
        report($sformatf("reply %0d status %0d, expected %0d", replies, got.status, want.status));
      if (got.found !== want.found)
        report($sformatf("reply %0d found %0b, expected %0b", replies, got.found, want.found));
      if (got.position !== want.position)
        report($sformatf("reply %0d position %0d, expected %0d", replies, got.position,
                         want.position));
      if (got.count !== want.count)
        report($sformatf("reply %0d count %0d, expected %0d", replies, got.count, want.count));
    endtask
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni;
  list_mirror   mirror;
  bit           long_hold_due;
  int unsigned  burst_left;
  int unsigned  held_cycles;
  stall_style_t stall_style;
  int unsigned  style_left;
  int unsigned  stall_phase;
  segment_t     segment;
  int unsigned  segment_left;
  int unsigned  drain_wait;

  blle_req_if req_if ();
  blle_rsp_if rsp_if ();

  bounded_linked_list_engine_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin : monitor
    reply_t seen;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        seen.status = rsp_if.status;
        seen.found = rsp_if.found;
        seen.position = rsp_if.position;
        seen.count = rsp_if.count;
        mirror.check_reply(seen);
      end
      if (req_if.valid && req_if.ready) mirror.note_request(req_if.mode, req_if.value);
    end
  end

  task automatic send_word(blle_pkg::mode_t m, blle_pkg::data_t v);
    int unsigned gap;
    req_if.valid <= 1'b1;
    req_if.mode <= m;
    req_if.value <= v;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic blle_pkg::data_t pick_value(int unsigned hit_pct);
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    n = mirror.mirror_values.size();
    if (r < hit_pct && n > 0) return mirror.mirror_values[$urandom_range(0, n - 1)];
    if (r < hit_pct + (100 - hit_pct) / 2) begin
      case ($urandom_range(0, 15))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return -32'sd1;
        default: return blle_pkg::data_t'($urandom_range(0, 12));
      endcase
    end
    return blle_pkg::data_t'($urandom());
  endfunction

  function automatic blle_pkg::mode_t pick_mode(segment_t seg);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (seg)
      SEG_FILL: begin
        if (r < 40) return blle_pkg::MODE_INS_FRONT;
        if (r < 80) return blle_pkg::MODE_INS_BACK;
        if (r < 90) return blle_pkg::MODE_SEARCH;
        return blle_pkg::MODE_DELETE;
      end
      SEG_DRAIN: begin
        if (r < 70) return blle_pkg::MODE_DELETE;
        if (r < 85) return blle_pkg::MODE_SEARCH;
        if (r < 93) return blle_pkg::MODE_INS_FRONT;
        return blle_pkg::MODE_INS_BACK;
      end
      default: return blle_pkg::mode_t'($urandom_range(0, 3));
    endcase
  endfunction

  initial begin : receiver
    rsp_if.ready = 1'b0;
    style_left = 0;
    stall_phase = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        held_cycles += 300;
        rsp_if.ready <= 1'b1;
      end else begin
        if (style_left == 0) begin
          stall_style = stall_style_t'($urandom_range(0, 3));
          style_left = $urandom_range(20, 120);
        end
        style_left--;
        stall_phase++;
        case (stall_style)
          ALWAYS_READY: rsp_if.ready <= 1'b1;
          COIN_FLIP: rsp_if.ready <= ($urandom_range(0, 1) == 1);
          EVERY_THIRD: rsp_if.ready <= (stall_phase % 3 != 0);
          default: rsp_if.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin : limit
    #5_000_000;
    $display("timeout after %0t", $time);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    blle_pkg::mode_t m;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.mode = blle_pkg::MODE_SEARCH;
    req_if.value = '0;
    long_hold_due = 1'b0;
    held_cycles = 0;
    burst_left = 6;
    mirror = new(CAPACITY);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list, both ends, duplicates, head, middle and tail removal, drain to empty.
    send_word(blle_pkg::MODE_SEARCH, 32'sd0);
    send_word(blle_pkg::MODE_DELETE, 32'sd0);
    send_word(blle_pkg::MODE_INS_FRONT, 32'sh7fff_ffff);
    send_word(blle_pkg::MODE_INS_BACK, 32'sh8000_0000);
    send_word(blle_pkg::MODE_INS_FRONT, -32'sd1);
    send_word(blle_pkg::MODE_INS_BACK, 32'sd0);
    send_word(blle_pkg::MODE_INS_BACK, 32'sh8000_0000);
    send_word(blle_pkg::MODE_SEARCH, 32'sh8000_0000);
    send_word(blle_pkg::MODE_SEARCH, 32'sh1234_5678);
    send_word(blle_pkg::MODE_DELETE, -32'sd1);
    send_word(blle_pkg::MODE_DELETE, 32'sd0);
    send_word(blle_pkg::MODE_DELETE, 32'sh8000_0000);
    send_word(blle_pkg::MODE_SEARCH, 32'sh8000_0000);
    send_word(blle_pkg::MODE_DELETE, 32'sh8000_0000);
    send_word(blle_pkg::MODE_INS_BACK, 32'sd1);
    send_word(blle_pkg::MODE_DELETE, 32'sd7);
    send_word(blle_pkg::MODE_DELETE, 32'sh7fff_ffff);
    send_word(blle_pkg::MODE_DELETE, 32'sd1);
    send_word(blle_pkg::MODE_SEARCH, 32'sd1);
    send_word(blle_pkg::MODE_INS_BACK, 32'sha5a5_a5a5);
    send_word(blle_pkg::MODE_INS_FRONT, 32'sh5a5a_5a5a);
    send_word(blle_pkg::MODE_DELETE, 32'sha5a5_a5a5);
    send_word(blle_pkg::MODE_SEARCH, 32'sh5a5a_5a5a);

    segment = SEG_FILL;
    segment_left = 70;
    for (int i = 0; i < 700; i++) begin
      if (i == 100 || i == 450) long_hold_due = 1'b1;
      if (segment_left == 0) begin
        segment = segment_t'($urandom_range(0, 2));
        segment_left = $urandom_range(40, 80);
      end
      segment_left--;
      m = pick_mode(segment);
      send_word(m, pick_value((segment == SEG_DRAIN) ? 85 : 45));
    end
    req_if.valid <= 1'b0;

    drain_wait = 0;
    while (mirror.pending_replies.size() != 0 && drain_wait < 20000) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (40) @(posedge clk_i);
    if (mirror.pending_replies.size() != 0)
      mirror.report($sformatf("%0d response words never arrived",
                              mirror.pending_replies.size()));

    $display("ran %0d requests and %0d response words, list peaked at %0d entries",
             mirror.requests, mirror.replies, mirror.peak);
    $display("hits %0d, full %0d, empty %0d, not found %0d, long hold %0d cycles",
             mirror.hits, mirror.fulls, mirror.empties, mirror.misses, held_cycles);
    if (mirror.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/blle_pkg.sv
rtl/blle_if.sv
rtl/blle_ram.sv
rtl/bounded_linked_list_engine_unit.sv
rtl/blle_chk.sv
bench/tb_bounded_linked_list_engine_unit.sv
